/* src/hsbf_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package hsbf_pkg;
  localparam int HW = 24;
  localparam int NW = 16;
  localparam int ONE_Q15 = 32768;
  localparam logic [31:0] SKEW_MIN_SQ = 32'd2684;
  // register indexes
  localparam logic [2:0] REG_ELEV_LOW = 3'd0;
  localparam logic [2:0] REG_ELEV_HIGH = 3'd1;
  localparam logic [2:0] REG_ELEV_REL = 3'd2;
  localparam logic [2:0] REG_SKEW_AMT = 3'd3;
  localparam logic [2:0] REG_SKEW_DIR = 3'd4;
  localparam logic [2:0] REG_SLOPE_LO = 3'd5;
  localparam logic [2:0] REG_SLOPE_HI = 3'd6;
  localparam logic [2:0] REG_SLOPE_REL = 3'd7;
  // sizes of the square-root and divider units
  localparam int SQRT_STAGES = 30;  // sqrt of a 60-bit radicand, one result bit per stage
  localparam int DIV_Q_BITS = 50;   // bound on the skew quotient in bits; the skew divider is 57 bits wide
  localparam int FD_Q_BITS = 16;    // bits of a fall-off quotient up to 32768; the fall-off dividers are 38 bits wide
endpackage
`default_nettype wire

/* src/hsbf_div.sv */
`timescale 1ns / 1ps
`default_nettype none
// Pipelined restoring divider, unsigned, one quotient bit per stage.
// Carries a side payload alongside the operands.
module hsbf_div import hsbf_pkg::*; #(
  parameter int NUM_W = 16,
  parameter int DEN_W = 16,
  parameter int SIDE_W = 8
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_vld,
  input  wire logic [NUM_W-1:0]  in_num,
  input  wire logic [DEN_W-1:0]  in_den,
  input  wire logic [SIDE_W-1:0] in_side,
  output logic                   out_vld,
  output logic [NUM_W-1:0]       out_quo,
  output logic [SIDE_W-1:0]      out_side
);
  localparam int RW = DEN_W + 1;
  logic [NUM_W:0]     vld_r;
  logic [NUM_W-1:0]   num_r  [NUM_W+1];
  logic [RW-1:0]      rem_r  [NUM_W+1];
  logic [DEN_W-1:0]   den_r  [NUM_W+1];
  logic [SIDE_W-1:0]  side_r [NUM_W+1];

  always_comb begin
    vld_r[0] = in_vld;
    num_r[0] = in_num;
    rem_r[0] = '0;
    den_r[0] = in_den;
    side_r[0] = in_side;
  end

  for (genvar s = 0; s < NUM_W; s++) begin : g_stage
    logic [RW-1:0] trial_nxt;
    logic [RW:0]   diff_nxt;
    always_comb begin
      trial_nxt = {rem_r[s][RW-2:0], num_r[s][NUM_W-1]};
      diff_nxt = {1'b0, trial_nxt} - {2'b00, den_r[s]};
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s+1] <= 1'b0;
      end else begin
        vld_r[s+1] <= vld_r[s];
      end
      den_r[s+1] <= den_r[s];
      side_r[s+1] <= side_r[s];
      if (!diff_nxt[RW]) begin
        rem_r[s+1] <= diff_nxt[RW-1:0];
        num_r[s+1] <= {num_r[s][NUM_W-2:0], 1'b1};
      end else begin
        rem_r[s+1] <= trial_nxt;
        num_r[s+1] <= {num_r[s][NUM_W-2:0], 1'b0};
      end
    end
  end

  assign out_vld = vld_r[NUM_W];
  assign out_quo = num_r[NUM_W];
  assign out_side = side_r[NUM_W];
endmodule
`default_nettype wire

/* src/height_slope_blend_factor_top.sv */
`timescale 1ns / 1ps
`default_nettype none
// Channel  | ports                                   | handshake
// input    | in_height, in_normal_x/y/z              | start && !busy
// result   | out_blend_weight                        | out_strobe, one cycle
// config   | cfg psel/penable/pwrite/paddr/pwdata... | APB, pready always high
// One texel enters every cycle; busy is tied low.
// From the accepting edge to the edge that takes the result the pipeline has
// 4 product/sum stages, 30 square-root stages, 57 skew-divider stages,
// 2 limit/compare stages, 38 fall-off divider stages and 3 product/output stages.
// Synchronous active-low reset clears valid bits and restores register defaults.
// The receiver cannot stall, so the pipeline never holds.
module height_slope_blend_factor_top import hsbf_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [23:0] in_height,
  input  wire logic [15:0] in_normal_x,
  input  wire logic [15:0] in_normal_y,
  input  wire logic [15:0] in_normal_z,
  output logic             out_strobe,
  output logic [15:0]      out_blend_weight,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  // ---------------- configuration registers
  logic signed [23:0] elo_r, ehi_r, skew_r;
  logic        [22:0] erel_r;
  logic        [31:0] sdir_r;
  logic signed [15:0] slo_r, shi_r;
  logic        [14:0] srel_r;
  logic [2:0] ridx;
  assign ridx = paddr[4:2];
  assign pready = 1'b1;
  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      elo_r <= '0; ehi_r <= '0; erel_r <= '0; skew_r <= '0; sdir_r <= '0;
      slo_r <= 16'sd16384; shi_r <= 16'sd16384; srel_r <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (ridx)
        REG_ELEV_LOW:  elo_r <= pwdata[23:0];
        REG_ELEV_HIGH: ehi_r <= pwdata[23:0];
        REG_ELEV_REL:  erel_r <= pwdata[22:0];
        REG_SKEW_AMT:  skew_r <= pwdata[23:0];
        REG_SKEW_DIR:  sdir_r <= pwdata;
        REG_SLOPE_LO:  slo_r <= pwdata[15:0];
        REG_SLOPE_HI:  shi_r <= pwdata[15:0];
        REG_SLOPE_REL: srel_r <= pwdata[14:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (ridx)
      REG_ELEV_LOW:  prdata = {8'd0, elo_r};
      REG_ELEV_HIGH: prdata = {8'd0, ehi_r};
      REG_ELEV_REL:  prdata = {9'd0, erel_r};
      REG_SKEW_AMT:  prdata = {8'd0, skew_r};
      REG_SKEW_DIR:  prdata = sdir_r;
      REG_SLOPE_LO:  prdata = {16'd0, slo_r};
      REG_SLOPE_HI:  prdata = {16'd0, shi_r};
      REG_SLOPE_REL: prdata = {17'd0, srel_r};
      default:       prdata = '0;
    endcase
  end

  // ---------------- stage 1: products of the normal
  logic s1_vld_r;
  logic signed [23:0] s1_h_r;
  logic signed [15:0] s1_ny_r;
  logic signed [31:0] s1_xx_r, s1_zz_r, s1_xc_r, s1_zs_r;
  always_ff @(posedge clk) begin
    if (!rst_n) s1_vld_r <= 1'b0;
    else        s1_vld_r <= start;
    s1_h_r  <= in_height;
    s1_ny_r <= in_normal_y;
    s1_xx_r <= $signed(in_normal_x) * $signed(in_normal_x);
    s1_zz_r <= $signed(in_normal_z) * $signed(in_normal_z);
    s1_xc_r <= $signed(in_normal_x) * $signed(sdir_r[15:0]);
    s1_zs_r <= $signed(in_normal_z) * $signed(sdir_r[31:16]);
  end

  // ---------------- stage 2: sums
  logic s2_vld_r;
  logic signed [23:0] s2_h_r;
  logic signed [15:0] s2_ny_r;
  logic [31:0] s2_sq_r;
  logic signed [32:0] s2_num_r;
  always_ff @(posedge clk) begin
    if (!rst_n) s2_vld_r <= 1'b0;
    else        s2_vld_r <= s1_vld_r;
    s2_h_r <= s1_h_r;
    s2_ny_r <= s1_ny_r;
    s2_sq_r <= s1_xx_r + s1_zz_r;
    s2_num_r <= 33'(s1_xc_r) + 33'(s1_zs_r);
  end

  // ---------------- stage 3: skew * num (57 bits) over two partial products
  // skew (24b) times num (33b): split num into high 17 and low 16 bits
  logic s3_vld_r;
  logic signed [23:0] s3_h_r;
  logic signed [15:0] s3_ny_r;
  logic [31:0] s3_sq_r;
  logic signed [40:0] s3_ph_r;
  logic signed [40:0] s3_pl_r;
  always_ff @(posedge clk) begin
    if (!rst_n) s3_vld_r <= 1'b0;
    else        s3_vld_r <= s2_vld_r;
    s3_h_r <= s2_h_r;
    s3_ny_r <= s2_ny_r;
    s3_sq_r <= s2_sq_r;
    s3_ph_r <= skew_r * $signed(s2_num_r[32:16]);
    s3_pl_r <= skew_r * $signed({1'b0, s2_num_r[15:0]});
  end

  // ---------------- stage 4: full product, sign and magnitude
  logic s4_vld_r;
  logic signed [23:0] s4_h_r;
  logic signed [15:0] s4_ny_r;
  logic [31:0] s4_sq_r;
  logic [56:0] s4_pmag_r;
  logic        s4_pneg_r;
  logic signed [57:0] prod_nxt;
  assign prod_nxt = (58'(s3_ph_r) <<< 16) + 58'(s3_pl_r);
  always_ff @(posedge clk) begin
    if (!rst_n) s4_vld_r <= 1'b0;
    else        s4_vld_r <= s3_vld_r;
    s4_h_r <= s3_h_r;
    s4_ny_r <= s3_ny_r;
    s4_sq_r <= s3_sq_r;
    s4_pneg_r <= prod_nxt[57];
    s4_pmag_r <= prod_nxt[57] ? 57'(-prod_nxt) : prod_nxt[56:0];
  end

  // ---------------- square root of sq << 28, one bit per stage
  // sq <= 2^31, radicand <= 2^59; result < 2^30
  typedef struct packed {
    logic signed [23:0] h;
    logic signed [15:0] ny;
    logic        skew_on;
    logic [56:0] pmag;
    logic        pneg;
  } sq_side_t;
  localparam int SQS_W = $bits(sq_side_t);

  logic [SQRT_STAGES:0] q_vld_r;
  logic [59:0]          q_rad_r [SQRT_STAGES+1];
  logic [31:0]          q_rem_r [SQRT_STAGES+1];
  logic [29:0]          q_root_r[SQRT_STAGES+1];
  sq_side_t             q_side_r[SQRT_STAGES+1];
  always_comb begin
    q_vld_r[0] = s4_vld_r;
    q_rad_r[0] = {s4_sq_r[31:0], 28'd0};
    q_rem_r[0] = '0;
    q_root_r[0] = '0;
    q_side_r[0] = '{h: s4_h_r, ny: s4_ny_r, skew_on: (s4_sq_r > SKEW_MIN_SQ),
                    pmag: s4_pmag_r, pneg: s4_pneg_r};
  end
  for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_sqrt
    logic [32:0] tr_nxt;
    logic [33:0] df_nxt;
    always_comb begin
      tr_nxt = {q_rem_r[k][30:0], q_rad_r[k][59:58]};
      df_nxt = {1'b0, tr_nxt} - {2'b00, q_root_r[k], 2'b01};
    end
    always_ff @(posedge clk) begin
      if (!rst_n) q_vld_r[k+1] <= 1'b0;
      else        q_vld_r[k+1] <= q_vld_r[k];
      q_rad_r[k+1] <= {q_rad_r[k][57:0], 2'b00};
      q_side_r[k+1] <= q_side_r[k];
      if (!df_nxt[33]) begin
        q_rem_r[k+1] <= df_nxt[31:0];
        q_root_r[k+1] <= {q_root_r[k][28:0], 1'b1};
      end else begin
        q_rem_r[k+1] <= tr_nxt[31:0];
        q_root_r[k+1] <= {q_root_r[k][28:0], 1'b0};
      end
    end
  end

  // ---------------- skew divide: |skew*num| / r (divisor 1 when skew is off)
  logic         d_vld;
  logic [56:0]  d_quo;
  logic [SQS_W-1:0] d_side_raw;
  sq_side_t     d_side;
  hsbf_div #(.NUM_W(57), .DEN_W(30), .SIDE_W(SQS_W)) u_skew_div (
    .clk(clk), .rst_n(rst_n),
    .in_vld(q_vld_r[SQRT_STAGES]),
    .in_num(q_side_r[SQRT_STAGES].pmag),
    .in_den(q_side_r[SQRT_STAGES].skew_on ? q_root_r[SQRT_STAGES] : 30'd1),
    .in_side(q_side_r[SQRT_STAGES]),
    .out_vld(d_vld), .out_quo(d_quo), .out_side(d_side_raw)
  );
  assign d_side = sq_side_t'(d_side_raw);

  // ---------------- shifted elevation limits
  // quotient magnitude is below 2^50 at most; keep 52-bit signed limits
  logic e1_vld_r;
  logic signed [51:0] e1_lo_r, e1_hi_r, e1_h_r;
  logic signed [15:0] e1_ny_r;
  logic signed [51:0] shift_nxt;
  logic signed [23:0] slo_sw, shi_sw, elo_sw, ehi_sw;
  always_comb begin
    if (!d_side.skew_on) shift_nxt = '0;
    else if (d_side.pneg) shift_nxt = -$signed({1'b0, d_quo[50:0]});
    else shift_nxt = $signed({1'b0, d_quo[50:0]});
    elo_sw = (elo_r > ehi_r) ? ehi_r : elo_r;
    ehi_sw = (elo_r > ehi_r) ? elo_r : ehi_r;
  end
  always_ff @(posedge clk) begin
    if (!rst_n) e1_vld_r <= 1'b0;
    else        e1_vld_r <= d_vld;
    e1_lo_r <= 52'(elo_sw) + shift_nxt;
    e1_hi_r <= 52'(ehi_sw) + shift_nxt;
    e1_h_r <= 52'(d_side.h);
    e1_ny_r <= d_side.ny;
  end

  // ---------------- classify both windows
  typedef struct packed {
    logic        e_band;
    logic        s_band;
    logic        out0;
  } cls_t;
  logic e2_vld_r;
  cls_t e2_cls_r;
  logic [51:0] e2_ed_r;
  logic [16:0] e2_sd_r;
  logic signed [16:0] slo_e, shi_e, ny_e;
  logic signed [52:0] ed_hi, ed_lo;
  logic e_band_nxt, e_out_nxt, s_band_nxt, s_out_nxt;
  logic [52:0] ed_nxt;
  logic signed [17:0] sd_hi, sd_lo;
  always_comb begin
    slo_sw = 24'(((slo_r > shi_r) ? shi_r : slo_r));
    shi_sw = 24'(((slo_r > shi_r) ? slo_r : shi_r));
    slo_e = 17'(slo_sw);
    shi_e = 17'(shi_sw);
    ny_e = 17'(e1_ny_r);
    ed_hi = 53'(e1_h_r) - 53'(e1_hi_r);
    ed_lo = 53'(e1_lo_r) - 53'(e1_h_r);
    e_out_nxt = (ed_hi > $signed(53'(erel_r))) || (ed_lo > $signed(53'(erel_r)));
    e_band_nxt = (ed_hi > 0) || (ed_lo > 0);
    ed_nxt = (ed_hi > 0) ? ed_hi : ed_lo;
    sd_hi = 18'(ny_e) - 18'(shi_e);
    sd_lo = 18'(slo_e) - 18'(ny_e);
    s_out_nxt = (sd_hi > $signed(18'(srel_r))) || (sd_lo > $signed(18'(srel_r)));
    s_band_nxt = (sd_hi > 0) || (sd_lo > 0);
  end
  always_ff @(posedge clk) begin
    if (!rst_n) e2_vld_r <= 1'b0;
    else        e2_vld_r <= e1_vld_r;
    e2_cls_r <= '{e_band: e_band_nxt, s_band: s_band_nxt,
                  out0: e_out_nxt || s_out_nxt};
    e2_ed_r <= ed_nxt[51:0];
    e2_sd_r <= (sd_hi > 0) ? sd_hi[16:0] : sd_lo[16:0];
  end

  // ---------------- fall-off quotients d*32768/b; d <= b so quotient <= 32768
  // numerator d<<15 with d < 2^23 fits 38 bits; quotient takes 16 bits wide result
  logic f_vld, f_svld;
  logic [37:0] fe_quo;
  logic [37:0] fs_quo;
  logic [2:0]  fe_side;
  logic [2:0]  fs_side;
  hsbf_div #(.NUM_W(38), .DEN_W(23), .SIDE_W(3)) u_elev_div (
    .clk(clk), .rst_n(rst_n), .in_vld(e2_vld_r),
    .in_num({e2_ed_r[22:0], 15'd0}),
    .in_den((erel_r == '0) ? 23'd1 : erel_r),
    .in_side(e2_cls_r),
    .out_vld(f_vld), .out_quo(fe_quo), .out_side(fe_side)
  );
  // slope divider padded to the same latency (38 stages)
  hsbf_div #(.NUM_W(38), .DEN_W(15), .SIDE_W(3)) u_slope_div (
    .clk(clk), .rst_n(rst_n), .in_vld(e2_vld_r),
    .in_num({6'd0, e2_sd_r[16:0], 15'd0}),
    .in_den((srel_r == '0) ? 15'd1 : srel_r),
    .in_side(e2_cls_r),
    .out_vld(f_svld), .out_quo(fs_quo), .out_side(fs_side)
  );

  // ---------------- factors
  logic m1_vld_r, m1_z_r;
  logic [16:0] ef_nxt, sf_nxt;
  cls_t fc;
  always_comb begin
    fc = cls_t'(fe_side);
    ef_nxt = fc.e_band ? 17'(ONE_Q15) - 17'(fe_quo[16:0]) : 17'(ONE_Q15);
    sf_nxt = fc.s_band ? 17'(ONE_Q15) - 17'(fs_quo[16:0]) : 17'(ONE_Q15);
  end
  logic [16:0] m1_ef17_r, m1_sf17_r;
  always_ff @(posedge clk) begin
    if (!rst_n) m1_vld_r <= 1'b0;
    else        m1_vld_r <= f_vld;
    m1_z_r <= fc.out0;
    m1_ef17_r <= ef_nxt;
    m1_sf17_r <= sf_nxt;
  end

  // ---------------- product and rounding
  logic m2_vld_r, m2_z_r;
  logic [33:0] m2_p_r;
  always_ff @(posedge clk) begin
    if (!rst_n) m2_vld_r <= 1'b0;
    else        m2_vld_r <= m1_vld_r;
    m2_z_r <= m1_z_r;
    m2_p_r <= m1_ef17_r * m1_sf17_r;
  end
  logic [34:0] rnd_nxt;
  assign rnd_nxt = 35'(m2_p_r) + 35'd16384;

  always_ff @(posedge clk) begin
    if (!rst_n) out_strobe <= 1'b0;
    else        out_strobe <= m2_vld_r;
    out_blend_weight <= m2_z_r ? 16'd0 : rnd_nxt[30:15];
  end

`ifndef ASSERT_OFF
  a_weight_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> out_blend_weight <= 16'd32768)
    else $error("weight above one");
  a_factor_range: assert property (@(posedge clk) disable iff (!rst_n)
    m1_vld_r && !m1_z_r |->
      (m1_ef17_r <= 17'(ONE_Q15)) && (m1_sf17_r <= 17'(ONE_Q15)))
    else $error("factor above one");
  a_div_align: assert property (@(posedge clk) disable iff (!rst_n)
    (f_vld == f_svld) && (!f_vld || (fs_side == fe_side)))
    else $error("fall-off dividers out of step");
  a_zero_out: assert property (@(posedge clk) disable iff (!rst_n)
    m2_vld_r && m2_z_r |=> out_strobe && out_blend_weight == 16'd0)
    else $error("outside window gave nonzero weight");
`endif
endmodule
`default_nettype wire
